FILE: sv/ess_pkg.sv
package ess_pkg;

   // Tail window: entry 0 is the newest byte.
   localparam int unsigned DEPTH = 6;
   typedef logic [DEPTH-1:0][7:0] window_type;

   // Characters used by the rules.
   localparam logic [7:0] CH_APOS = 8'h27;
   localparam logic [7:0] CH_A    = 8'h61;
   localparam logic [7:0] CH_C    = 8'h63;
   localparam logic [7:0] CH_D    = 8'h64;
   localparam logic [7:0] CH_E    = 8'h65;
   localparam logic [7:0] CH_F    = 8'h66;
   localparam logic [7:0] CH_G    = 8'h67;
   localparam logic [7:0] CH_H    = 8'h68;
   localparam logic [7:0] CH_I    = 8'h69;
   localparam logic [7:0] CH_L    = 8'h6c;
   localparam logic [7:0] CH_N    = 8'h6e;
   localparam logic [7:0] CH_O    = 8'h6f;
   localparam logic [7:0] CH_R    = 8'h72;
   localparam logic [7:0] CH_S    = 8'h73;
   localparam logic [7:0] CH_T    = 8'h74;
   localparam logic [7:0] CH_U    = 8'h75;
   localparam logic [7:0] CH_V    = 8'h76;
   localparam logic [7:0] CH_X    = 8'h78;
   localparam logic [7:0] CH_Y    = 8'h79;
   localparam logic [7:0] CH_Z    = 8'h7a;

   // Suffix codes appended to a stem.
   localparam logic [2:0] APP_NONE = 3'd0;
   localparam logic [2:0] APP_E    = 3'd1;
   localparam logic [2:0] APP_Y    = 3'd2;
   localparam logic [2:0] APP_LE   = 3'd3;
   localparam logic [2:0] APP_FE   = 3'd4;

   // One candidate stem, laid out as it leaves on the result channel.
   typedef struct packed {
      logic       last;
      logic [2:0] app;
      logic [2:0] strip;
   } cand_type;

   // Up to two candidates for one word.
   typedef struct packed {
      logic [1:0] count;
      cand_type   c0;
      cand_type   c1;
   } result_type;

   // Byte k from the word end, k = 1 is the last; zero outside the window.
   function automatic logic [7:0] ch(window_type w, logic [2:0] k);
      logic [7:0] r;
      r = 8'h00;
      if (k >= 3'd1 && k <= 3'd6) begin
         r = w[k - 3'd1];
      end
      return r;
   endfunction

   function automatic logic is_vowel(logic [7:0] x);
      return x == CH_A || x == CH_E || x == CH_I || x == CH_O || x == CH_U || x == CH_Y;
   endfunction

   function automatic logic is_liquid(logic [7:0] x);
      return x == CH_L || x == CH_R || x == CH_S || x == CH_V || x == CH_Z;
   endfunction

   function automatic result_type one(logic [2:0] strip, logic [2:0] app);
      result_type r;
      r = '0;
      r.count    = 2'd1;
      r.c0.strip = strip;
      r.c0.app   = app;
      return r;
   endfunction

   function automatic result_type two(logic [2:0] s0, logic [2:0] a0,
                                      logic [2:0] s1, logic [2:0] a1);
      result_type r;
      r = '0;
      r.count    = 2'd2;
      r.c0.strip = s0;
      r.c0.app   = a0;
      r.c1.strip = s1;
      r.c1.app   = a1;
      return r;
   endfunction

   // Plural and possessive rules with o characters already stripped.
   function automatic result_type plural(window_type w, logic [2:0] o);
      logic [7:0] d1;
      logic [7:0] d2;
      logic [7:0] d3;
      result_type r;
      d1 = ch(w, o + 3'd1);
      d2 = ch(w, o + 3'd2);
      d3 = ch(w, o + 3'd3);
      if (d1 != CH_E) begin
         r = one(o, APP_NONE);
      end else if (d2 == CH_I) begin
         r = one(o + 3'd2, APP_Y);
      end else if (d2 == CH_H) begin
         r = one((d3 == CH_T) ? o : o + 3'd1, APP_NONE);
      end else if (d2 == CH_X) begin
         r = one(o + 3'd1, APP_NONE);
      end else if (d2 == CH_S || d2 == CH_Z) begin
         r = one((d3 == CH_S || d3 == CH_Z) ? o + 3'd1 : o, APP_NONE);
      end else if (d2 == CH_V) begin
         r = two(o, APP_NONE, o + 3'd2, APP_FE);
      end else begin
         r = one(o, APP_NONE);
      end
      return r;
   endfunction

   // Ending repair rules after ing/ed/en/er/est with o characters stripped.
   function automatic result_type repair(window_type w, logic [2:0] o);
      logic [7:0] d1;
      logic [7:0] d2;
      logic [7:0] d3;
      logic       noend;
      result_type r;
      d1 = ch(w, o + 3'd1);
      d2 = ch(w, o + 3'd2);
      d3 = ch(w, o + 3'd3);
      noend = d1 == CH_C || d1 == CH_G || d1 == CH_S || d1 == CH_V || d1 == CH_Z;
      r = '0;
      if (is_vowel(d1)) begin
         if (d1 == CH_I) begin
            r = one(o + 3'd1, APP_Y);
         end else if (d1 == CH_Y) begin
            r = one(o, APP_NONE);
         end else if (d1 == CH_E) begin
            r = (d2 == CH_E) ? one(o, APP_NONE) : two(o, APP_NONE, o, APP_E);
         end else begin
            r = one(o, APP_E);
         end
      end else if (d1 == CH_H) begin
         r = (d2 == CH_T) ? two(o, APP_NONE, o, APP_E) : one(o, APP_NONE);
      end else if (d1 == d2) begin
         r = is_liquid(d1) ? two(o, APP_NONE, o + 3'd1, APP_NONE)
                           : one(o + 3'd1, APP_NONE);
      end else if (is_vowel(d2)) begin
         if (is_vowel(d3)) begin
            r = one(o, noend ? APP_E : APP_NONE);
         end else begin
            r = one(o, APP_E);
         end
      end else if (is_liquid(d1)) begin
         r = (d1 == CH_L && d2 == CH_R) ? one(o, APP_NONE) : one(o, APP_E);
      end
      return r;
   endfunction

endpackage

FILE: sv/ess_rules.sv
// Suffix decision tree over a finished word's tail window.
module ess_rules (
   input  ess_pkg::window_type window,
   output ess_pkg::result_type result
);

   logic [7:0]          c1;
   logic [7:0]          c2;
   logic [7:0]          c3;
   ess_pkg::result_type raw;

   assign c1 = window[0];
   assign c2 = window[1];
   assign c3 = window[2];

   // Pick the first suffix rule that matches the word end.
   always_comb begin
      raw = '0;
      if (c1 == ess_pkg::CH_T && c2 == ess_pkg::CH_APOS && c3 == ess_pkg::CH_N) begin
         raw = ess_pkg::one(3'd3, ess_pkg::APP_NONE);
      end else if (c1 == ess_pkg::CH_S && c2 == ess_pkg::CH_APOS) begin
         raw = ess_pkg::one(3'd2, ess_pkg::APP_NONE);
      end else if (c1 == ess_pkg::CH_APOS) begin
         raw = ess_pkg::plural(window, 3'd2);
      end else if (c1 == ess_pkg::CH_S) begin
         raw = ess_pkg::plural(window, 3'd1);
      end else if (c1 == ess_pkg::CH_Y && c2 == ess_pkg::CH_L) begin
         if (c3 == ess_pkg::CH_I) begin
            raw = ess_pkg::one(3'd3, ess_pkg::APP_Y);
         end else begin
            raw = ess_pkg::two(3'd2, ess_pkg::APP_NONE, 3'd2, ess_pkg::APP_LE);
         end
      end else if (c1 == ess_pkg::CH_G && c2 == ess_pkg::CH_N && c3 == ess_pkg::CH_I) begin
         raw = ess_pkg::repair(window, 3'd3);
      end else if ((c1 == ess_pkg::CH_D || c1 == ess_pkg::CH_N || c1 == ess_pkg::CH_R)
                   && c2 == ess_pkg::CH_E) begin
         raw = ess_pkg::repair(window, 3'd2);
      end else if (c1 == ess_pkg::CH_T && c2 == ess_pkg::CH_S && c3 == ess_pkg::CH_E) begin
         raw = ess_pkg::repair(window, 3'd3);
      end
   end

   // Mark the final candidate of the word.
   always_comb begin
      result = raw;
      if (raw.count == 2'd1) begin
         result.c0.last = 1'b1;
      end else if (raw.count == 2'd2) begin
         result.c1.last = 1'b1;
      end
   end

endmodule

FILE: sv/english_suffix_stemmer.sv
// English suffix stemmer.
// The request channel carries one byte of a word per transfer; req_tlast marks
// the final byte. On that byte the last six bytes are run through the
// suffix rules, and zero to two candidate stems leave on the response
// channel, one per transfer, each a strip count and an append code, with
// rsp_tlast on the final candidate of the word. A word with no matching
// rule gives no response at all.
// A word's first candidate passes the analysis register, then the result
// register, before it is valid; a busy result register holds it back.
// Throughput: one byte per cycle while the receiver keeps up; words that
// end in back-to-back cycles are also taken at full rate as long as each
// gives at most one candidate, since the result register drains one
// candidate per cycle while rsp_tready is high.
// When the receiver stalls, the result register holds and the analysis
// register fills; further bytes are refused once both are occupied.
// Reset clears the tail window and empties both registers.
module english_suffix_stemmer (
   input  logic       clock,
   input  logic       reset,
   // req_tdata: [7:0] character
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   // rsp_tdata: [2:0] strip_count, [5:3] append_code, [7:6] zero
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast
);

   ess_pkg::window_type window_ff;
   ess_pkg::window_type window_in;
   ess_pkg::window_type shifted;
   ess_pkg::window_type s1_win_ff;
   ess_pkg::window_type s1_win_in;
   logic                s1_valid_ff;
   logic                s1_valid_in;
   ess_pkg::result_type result;
   ess_pkg::cand_type   ent0_ff;
   ess_pkg::cand_type   ent0_in;
   ess_pkg::cand_type   ent1_ff;
   ess_pkg::cand_type   ent1_in;
   logic [1:0]          cnt_ff;
   logic [1:0]          cnt_in;
   logic                req_fire;
   logic                rsp_fire;
   logic                free_next;
   logic                s1_move;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;
   assign free_next = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_fire);
   assign s1_move   = s1_valid_ff && free_next;
   assign req_tready = !s1_valid_ff || s1_move;

   // Shift the new byte into the tail window; a word end clears it.
   always_comb begin
      shifted   = {window_ff[4:0], req_tdata};
      window_in = window_ff;
      s1_win_in = s1_win_ff;
      if (req_fire) begin
         if (req_tlast) begin
            window_in = '0;
            s1_win_in = shifted;
         end else begin
            window_in = shifted;
         end
      end
   end

   // Analysis register holds a finished word until the result register frees.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire && req_tlast) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   ess_rules u_rules (
      .window (s1_win_ff),
      .result (result)
   );

   // Result register: two candidate slots drained one candidate at a time.
   always_comb begin
      ent0_in = ent0_ff;
      ent1_in = ent1_ff;
      cnt_in  = cnt_ff;
      if (s1_move) begin
         ent0_in = result.c0;
         ent1_in = result.c1;
         cnt_in  = result.count;
      end else if (rsp_fire) begin
         ent0_in = ent1_ff;
         cnt_in  = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= '0;
         s1_valid_ff <= 1'b0;
         cnt_ff      <= 2'd0;
      end else begin
         window_ff   <= window_in;
         s1_valid_ff <= s1_valid_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_win_ff <= s1_win_in;
      ent0_ff   <= ent0_in;
      ent1_ff   <= ent1_in;
   end

   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_tdata  = {2'b00, ent0_ff.app, ent0_ff.strip};
   assign rsp_tlast  = ent0_ff.last;

   // The final candidate of a word is always the only one left in the buffer.
   a_last_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast) |-> cnt_ff == 2'd1)
      else $error("final candidate left with another one behind it");

   // With two candidates buffered, the front one is never the final one.
   a_two_front: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !ent0_ff.last)
      else $error("front candidate marked final while two are buffered");

   // A word end leaves an empty tail window behind.
   a_window_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> window_ff == '0)
      else $error("tail window not cleared after word end");

   // A stalled analysis register keeps its word.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> s1_valid_ff && $stable(s1_win_ff))
      else $error("pending word lost from analysis register");

endmodule
